// File: sv/fwsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and command codes for the searchable id queue.
package fwsc_pkg;

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] item_id;
  } in_item_t;

  typedef struct packed {
    logic [31:0] dequeued_id;
    logic [6:0]  position;
    logic        found;
    logic        changed;
    logic        overflow;
    logic [6:0]  queue_length;
  } out_item_t;

endpackage

// File: sv/fwsc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module fwsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/fifo_with_search_and_cancel_unit.sv
`timescale 1ns / 1ps
// Top level: bounded id queue with position query and remove-all, held in one RAM.
// Enqueue goes straight to emit, dequeue via a RAM read state, query and remove
// via an entry scan (query ends at the first match); an empty queue skips both.
// The next item is taken once the result moves to the output register.
// Query and remove walk the entries at one read per cycle of the RAM read port.
// Reset clears count, pointers and handshake state; RAM contents are not cleared.
module fifo_with_search_and_cancel_unit
  import fwsc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEQ,
    ST_SCAN,
    ST_EMIT
  } state_e;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (a == AW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = a + AW'(1);
    end
    return r;
  endfunction

  function automatic logic [6:0] low7(input logic [CW-1:0] v);
    logic [XW-1:0] x;
    x = XW'(v);
    return x[6:0];
  endfunction

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic [AW-1:0] cmp_idx_q, cmp_idx_d;
  logic [CW-1:0] w_cnt_q, w_cnt_d;
  cmd_e          cmd_q, cmd_d;
  logic [31:0]   id_q, id_d;
  out_item_t     pend_q, pend_d;
  out_item_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic          accept;
  logic          match;
  logic          last;
  logic [CW-1:0] w_next;
  logic [AW-1:0] wr_addr_next;

  fwsc_ram #(
    .WIDTH(32),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign ram_raddr   = (state_q == ST_SCAN) ? rd_addr_q : head_q;
  assign match       = (ram_rdata == id_q);
  assign last        = ((CW'(cmp_idx_q) + CW'(1)) == count_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    tail_d       = tail_q;
    rd_addr_d    = rd_addr_q;
    wr_addr_d    = wr_addr_q;
    cmp_idx_d    = cmp_idx_q;
    w_cnt_d      = w_cnt_q;
    cmd_d        = cmd_q;
    id_d         = id_q;
    pend_d       = pend_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ram_we       = 1'b0;
    ram_waddr    = tail_q;
    ram_wdata    = in_item_i.item_id;
    w_next       = w_cnt_q;
    wr_addr_next = wr_addr_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d  = in_item_i.command;
          id_d   = in_item_i.item_id;
          pend_d = '0;
          pend_d.queue_length = low7(count_q);
          state_d = ST_EMIT;
          case (in_item_i.command)
            CMD_ENQ: begin
              if (count_q < CW'(QUEUE_DEPTH)) begin
                ram_we  = 1'b1;
                tail_d  = wrap_inc(tail_q);
                count_d = count_q + CW'(1);
                pend_d.changed      = 1'b1;
                pend_d.queue_length = low7(count_q + CW'(1));
              end else begin
                pend_d.overflow = 1'b1;
              end
            end
            CMD_DEQ: begin
              if (count_q != '0) begin
                state_d = ST_DEQ;
              end
            end
            default: begin
              if (count_q != '0) begin
                rd_addr_d = wrap_inc(head_q);
                wr_addr_d = head_q;
                cmp_idx_d = '0;
                w_cnt_d   = '0;
                state_d   = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_DEQ: begin
        pend_d.dequeued_id  = ram_rdata;
        pend_d.changed      = 1'b1;
        pend_d.queue_length = low7(count_q - CW'(1));
        count_d = count_q - CW'(1);
        head_d  = wrap_inc(head_q);
        state_d = ST_EMIT;
      end
      ST_SCAN: begin
        rd_addr_d = wrap_inc(rd_addr_q);
        cmp_idx_d = cmp_idx_q + AW'(1);
        if (cmd_q == CMD_QUERY) begin
          if (match) begin
            pend_d.position = low7(CW'(cmp_idx_q) + CW'(1));
            pend_d.found    = 1'b1;
            state_d = ST_EMIT;
          end else if (last) begin
            state_d = ST_EMIT;
          end
        end else begin
          if (!match) begin
            ram_we       = 1'b1;
            ram_waddr    = wr_addr_q;
            ram_wdata    = ram_rdata;
            w_next       = w_cnt_q + CW'(1);
            wr_addr_next = wrap_inc(wr_addr_q);
          end
          w_cnt_d   = w_next;
          wr_addr_d = wr_addr_next;
          if (last) begin
            count_d = w_next;
            tail_d  = wr_addr_next;
            pend_d.changed      = (w_next != count_q);
            pend_d.queue_length = low7(w_next);
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      rd_addr_q   <= '0;
      wr_addr_q   <= '0;
      cmp_idx_q   <= '0;
      w_cnt_q     <= '0;
      cmd_q       <= CMD_ENQ;
      id_q        <= '0;
      pend_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      rd_addr_q   <= rd_addr_d;
      wr_addr_q   <= wr_addr_d;
      cmp_idx_q   <= cmp_idx_d;
      w_cnt_q     <= w_cnt_d;
      cmd_q       <= cmd_d;
      id_q        <= id_d;
      pend_q      <= pend_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above capacity");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE || state_q == ST_SCAN))
    else $error("RAM write outside idle or scan");

  a_compact_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (w_cnt_q <= CW'(cmp_idx_q)))
    else $error("compaction write pointer ahead of read");

  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.found == (out_q.position != '0)))
    else $error("found disagrees with position");

  a_ovf_nochg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.overflow && out_q.changed))
    else $error("overflow and changed both set");

endmodule

// File: bench/tb_fifo_with_search_and_cancel_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the searchable id queue: directed and random items, scoreboard.
module tb_fifo_with_search_and_cancel_unit;
  import fwsc_pkg::*;

  localparam int QUEUE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 1330;
  localparam int CALM_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_PRINTS   = 20;

  class id_queue_scoreboard;
    logic [31:0] held_ids[$];
    out_item_t   awaited[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned cmd_count[4];
    int unsigned overflow_count;
    int unsigned hit_count;
    int unsigned peak_length;

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < MAX_PRINTS) begin
        $display("%0t: mismatch on %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
      end
      mismatches++;
    endtask

    function void note_item(in_item_t it);
      out_item_t   r;
      logic [31:0] kept[$];
      int          pos;
      r   = '0;
      pos = 0;
      cmd_count[it.command]++;
      case (it.command)
        CMD_ENQ: begin
          if (held_ids.size() < QUEUE_DEPTH) begin
            held_ids.push_back(it.item_id);
            r.changed = 1'b1;
          end else begin
            r.overflow = 1'b1;
            overflow_count++;
          end
        end
        CMD_DEQ: begin
          if (held_ids.size() > 0) begin
            r.dequeued_id = held_ids.pop_front();
            r.changed     = 1'b1;
          end
        end
        CMD_QUERY: begin
          for (int i = 0; i < held_ids.size(); i++) begin
            if (held_ids[i] == it.item_id) begin
              pos = i + 1;
              break;
            end
          end
          if (pos > 0) hit_count++;
        end
        CMD_REMOVE: begin
          foreach (held_ids[i]) begin
            if (held_ids[i] != it.item_id) kept.push_back(held_ids[i]);
          end
          if (kept.size() != held_ids.size()) r.changed = 1'b1;
          held_ids = kept;
        end
      endcase
      r.position     = pos[6:0];
      r.found        = (pos > 0);
      r.queue_length = 7'(held_ids.size());
      if (held_ids.size() > peak_length) peak_length = held_ids.size();
      awaited.push_back(r);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected result, dequeued_id", got.dequeued_id, '0);
        return;
      end
      want = awaited.pop_front();
      if (got.dequeued_id !== want.dequeued_id)
        report_mismatch("dequeued_id", got.dequeued_id, want.dequeued_id);
      if (got.position !== want.position)
        report_mismatch("position", 32'(got.position), 32'(want.position));
      if (got.found !== want.found)
        report_mismatch("found", 32'(got.found), 32'(want.found));
      if (got.changed !== want.changed)
        report_mismatch("changed", 32'(got.changed), 32'(want.changed));
      if (got.overflow !== want.overflow)
        report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
      if (got.queue_length !== want.queue_length)
        report_mismatch("queue_length", 32'(got.queue_length), 32'(want.queue_length));
    endtask
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  id_queue_scoreboard sb;
  bit          idle_on = 1'b0;
  int unsigned items_sent = 0;

  fifo_with_search_and_cancel_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_cmd(cmd_e c, logic [31:0] id);
    in_item_t it;
    it.command = c;
    it.item_id = id;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sb.held_ids.size() > 0 && r < 55)
      return sb.held_ids[$urandom_range(0, sb.held_ids.size() - 1)];
    if (r < 80)
      return ($urandom_range(0, 1) ? 32'hFFFF_FFF8 : 32'h0) | 32'($urandom_range(0, 7));
    return $urandom();
  endfunction

  function automatic cmd_e pick_cmd(int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      0:       return r < 70 ? CMD_ENQ : r < 80 ? CMD_DEQ : r < 90 ? CMD_QUERY : CMD_REMOVE;
      1:       return r < 15 ? CMD_ENQ : r < 70 ? CMD_DEQ : r < 85 ? CMD_QUERY : CMD_REMOVE;
      default: return r < 35 ? CMD_ENQ : r < 60 ? CMD_DEQ : r < 85 ? CMD_QUERY : CMD_REMOVE;
    endcase
  endfunction

  always @(posedge clk_i) begin : result_sink
    int stall_left;
    if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
    if (!rst_ni) begin
      stall_left = 0;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned phase_len;
    int unsigned mode;
    int unsigned phase_no;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(CMD_DEQ, 32'h0);
    send_cmd(CMD_QUERY, 32'h0);
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF);
    send_cmd(CMD_ENQ, 32'h0);
    send_cmd(CMD_ENQ, 32'hFFFF_FFFF);
    send_cmd(CMD_ENQ, 32'h1234_5678);
    send_cmd(CMD_ENQ, 32'h0);
    send_cmd(CMD_ENQ, 32'hFFFF_FFFF);
    send_cmd(CMD_QUERY, 32'h0);
    send_cmd(CMD_QUERY, 32'hFFFF_FFFF);
    send_cmd(CMD_QUERY, 32'hA5A5_A5A5);
    send_cmd(CMD_REMOVE, 32'h0);
    send_cmd(CMD_QUERY, 32'h0);
    send_cmd(CMD_REMOVE, 32'h5A5A_5A5A);
    send_cmd(CMD_QUERY, 32'h1234_5678);
    send_cmd(CMD_DEQ, 32'hDEAD_BEEF);
    send_cmd(CMD_DEQ, 32'h0);
    send_cmd(CMD_DEQ, 32'h0);
    send_cmd(CMD_DEQ, 32'h0);
    send_cmd(CMD_ENQ, 32'h0);
    send_cmd(CMD_DEQ, 32'hFFFF_FFFF);
    hold_until_drained();

    phase_no = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      idle_on = (items_sent < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
      mode = (phase_no % 4 == 0) ? 3 : $urandom_range(0, 2);
      if (mode == 3) begin
        while (sb.held_ids.size() < QUEUE_DEPTH) send_cmd(CMD_ENQ, $urandom());
        repeat ($urandom_range(1, 3)) send_cmd(CMD_ENQ, pick_id());
        send_cmd(CMD_QUERY, sb.held_ids[$]);
        repeat ($urandom_range(2, 6)) send_cmd(CMD_QUERY, pick_id());
        send_cmd(CMD_REMOVE, pick_id());
      end else begin
        phase_len = $urandom_range(30, 120);
        repeat (phase_len) send_cmd(pick_cmd(mode), pick_id());
      end
      if (phase_no == 0 || $urandom_range(0, 2) == 0) hold_until_drained();
      phase_no++;
    end

    idle_on = 1'b0;
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d enqueues, %0d dequeues, %0d queries (%0d hits), %0d removes",
             sb.cmd_count[CMD_ENQ], sb.cmd_count[CMD_DEQ], sb.cmd_count[CMD_QUERY],
             sb.hit_count, sb.cmd_count[CMD_REMOVE]);
    $display("Results checked %0d, overflows %0d, peak length %0d, mismatches %0d",
             sb.results_seen, sb.overflow_count, sb.peak_length, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
